### src/dbo_pkg.sv
// ----------------------------------------------------------------------------
// dbo_pkg: shared types and constants of the drawbar organ voice
// Sequencer states, register indexes, footage ratios and fixed-point factors.
// ----------------------------------------------------------------------------
package dbo_pkg;

  // Fixed widths of the request and result fields.
  localparam int STEP_W      = 24;
  localparam int SCATTER_W   = 54;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 36;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DRAWBARS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTARY_AMT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_LEVEL  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_DECAY  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTARY_STEP  = 3'd4;

  // Command codes.
  localparam logic CMD_NOTE_ON = 1'b0;

  // Reset values of the registers that do not reset to zero.
  localparam logic [15:0] CLICK_DECAY_RST = 16'd63222;
  localparam logic [23:0] ROTARY_STEP_RST = 24'd2237;

  // Twice the footage ratio of each partial; partials past nine are silent.
  localparam logic [4:0] RATIO2 [16] = '{5'd1, 5'd3, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12,
                                        5'd16, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

  // A partial stays live while 10 * step * ratio2 is below 9 * 2^24.
  localparam logic [31:0] MUTE_LIMIT = 32'd150994944;

  localparam longint             PI_HALF_Q30 = 64'sd1686629713;
  localparam logic signed [16:0] VIB_K       = 17'sd16843;
  localparam logic [12:0]        TREM_K      = 13'd7237;
  localparam logic signed [16:0] CLICK_K     = 17'sd45875;
  localparam logic [15:0]        TREM_UNITY  = 16'h8000;
  localparam logic [15:0]        CLICK_MIN   = 16'd32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NOTE,
    S_NOTE_END,
    S_LFO_STEP,
    S_LFO_MUL,
    S_LFO_TREM,
    S_RD,
    S_CHK,
    S_VIB,
    S_UPD,
    S_ACC,
    S_MIX,
    S_SCALE,
    S_CLICK,
    S_OUT
  } state_t;

endpackage

### src/dbo_ram.sv
// ----------------------------------------------------------------------------
// dbo_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module dbo_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/drawbar_additive_organ_voice_top.sv
// ----------------------------------------------------------------------------
// drawbar_additive_organ_voice_top: nine-partial drawbar organ voice
// Fixed-point additive voice with rotary vibrato/tremolo and a key click.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_ready with command, pitch_step, phase_scatter
// and noise_value. A note_on request (command 0) latches the drawbars, mutes
// partials near Nyquist, loads the start phases and the click envelope and
// gives no result. A render request (command 1) gives one audio_out sample on
// out_valid/out_ready. Registers are written through cfg_we/cfg_index/cfg_data;
// the user is to write them only while the voice is idle; the block itself
// does not enforce this. A render works through the partials in turn, with a
// read-modify-write of the phase RAM and a serial multiply chain (vibrato,
// then sine lookup and weighting) for each sounding partial; silent partials
// skip the chain, and the LFO steps come first when the rotary is on.
// The finished sample sits in an output register, so a new request is taken
// while it waits; a later render holds in its last step until the sample is
// taken. Reset restores the register defaults, mutes all partials and clears
// the envelope, mix gain and rotary phase.
// ----------------------------------------------------------------------------
module drawbar_additive_organ_voice_top #(
  parameter int PARTIALS       = 9,
  parameter int PHASE_BITS     = 24,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dbo_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [dbo_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  command,
  input  logic [dbo_pkg::STEP_W-1:0]            pitch_step,
  input  logic [dbo_pkg::SCATTER_W-1:0]         phase_scatter,
  input  logic signed [dbo_pkg::SAMPLE_W-1:0]   noise_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dbo_pkg::SAMPLE_W-1:0]   audio_out
);

  import dbo_pkg::*;

  localparam int IW      = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
  localparam int QBITS   = SINE_ADDR_BITS - 2;
  localparam int QUARTER = 1 << QBITS;
  localparam int SIDX_W  = QBITS + 1;
  localparam int NSUM    = 8 * PARTIALS + 1;
  localparam int SUM_W   = $clog2(NSUM);
  localparam int ENTRY_W = PHASE_BITS + 4;
  localparam int UP      = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
  localparam int DN      = (PHASE_BITS >= 24) ? 0 : 24 - PHASE_BITS;
  localparam int IF_W    = PHASE_BITS + 5;
  localparam int TL_W    = 26;
  localparam int P1_W    = PHASE_BITS + 1 + TL_W;
  localparam int D1_W    = P1_W - 15;
  localparam int P2_W    = D1_W + 17;
  localparam int ACC_W   = 19 + $clog2(PARTIALS + 1);
  localparam int M1_W    = ACC_W + 17;
  localparam int S1_W    = M1_W - 15;
  localparam int M2_W    = S1_W + 17;
  localparam int TOT_W   = M2_W - 14;
  localparam int C1_W    = 33;
  localparam int C2_W    = 50;
  localparam int CK_W    = C2_W - 32;

  typedef logic [15:0]           sine_tab_t  [QUARTER+1];
  typedef logic [PHASE_BITS-1:0] base_tab_t  [PARTIALS];
  typedef logic [PHASE_BITS-1:0] scat_tab_t  [64];

  // Quarter-wave sine, Taylor series to x^11 in Q2.30, rounded to Q1.15.
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint    x, x2, t, s, v;
    int        r;
    for (r = 0; r <= QUARTER; r++) begin
      x  = (longint'(r) * PI_HALF_Q30) >>> QBITS;
      x2 = (x * x) / 64'sd1073741824;
      t  = x;
      s  = x;
      t  = -((t * x2) / 64'sd1073741824) / 64'sd6;
      s  = s + t;
      t  = -((t * x2) / 64'sd1073741824) / 64'sd20;
      s  = s + t;
      t  = -((t * x2) / 64'sd1073741824) / 64'sd42;
      s  = s + t;
      t  = -((t * x2) / 64'sd1073741824) / 64'sd72;
      s  = s + t;
      t  = -((t * x2) / 64'sd1073741824) / 64'sd110;
      s  = s + t;
      v  = (s + 64'sd16384) / 64'sd32768;
      if (v > 64'sd32767) begin
        v = 64'sd32767;
      end
      if (v < 64'sd0) begin
        v = 64'sd0;
      end
      tab[r] = v[15:0];
    end
    return tab;
  endfunction

  // Start phase of each partial: 0.13 * i of a cycle, rounded.
  function automatic base_tab_t build_base();
    base_tab_t tab;
    int        i;
    for (i = 0; i < PARTIALS; i++) begin
      tab[i] = PHASE_BITS'(((longint'(13 * i) <<< PHASE_BITS) + 64'sd50) / 64'sd100);
    end
    return tab;
  endfunction

  // Phase scatter of a 6-bit random k: k/64 * 0.05 of a cycle.
  function automatic scat_tab_t build_scat();
    scat_tab_t tab;
    int        k;
    for (k = 0; k < 64; k++) begin
      tab[k] = PHASE_BITS'((longint'(k) <<< PHASE_BITS) / 64'sd1280);
    end
    return tab;
  endfunction

  function automatic longint trunc_shift(input longint x, input int n);
    longint bias;
    bias = (x < 0) ? ((64'sd1 <<< n) - 64'sd1) : 64'sd0;
    return (x + bias) >>> n;
  endfunction

  function automatic logic [SIDX_W-1:0] sine_index(input logic [PHASE_BITS-1:0] ph);
    logic [SINE_ADDR_BITS-1:0] k;
    logic [QBITS-1:0]          r;
    k = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
    r = k[QBITS-1:0];
    if (k[SINE_ADDR_BITS-2]) begin
      return SIDX_W'(QUARTER) - {1'b0, r};
    end
    return {1'b0, r};
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam base_tab_t BASE_TAB = build_base();
  localparam scat_tab_t SCAT_TAB = build_scat();
  localparam logic [PHASE_BITS-1:0] INC_MAX =
    PHASE_BITS'(((64'sd49 <<< PHASE_BITS) + 64'sd50) / 64'sd100);

  // Configuration registers.
  logic [35:0] drawbar_levels;
  logic [7:0]  rotary_amount;
  logic [7:0]  click_level;
  logic [15:0] click_decay;
  logic [23:0] rotary_step;

  // Control and voice state.
  state_t                state, state_next;
  logic [IW-1:0]         part;
  logic [SUM_W-1:0]      level_sum;
  logic [PARTIALS-1:0]   valid;
  logic [15:0]           mix_norm;
  logic [15:0]           click_env;
  logic [PHASE_BITS-1:0] lfo_phase;

  // Latched request fields.
  logic [STEP_W-1:0]          step_q;
  logic [SCATTER_W-1:0]       scatter_q;
  logic signed [SAMPLE_W-1:0] noise_q;

  // Datapath registers.
  logic                     rd_ok;
  logic [PHASE_BITS-1:0]    inc;
  logic [3:0]               cur_lvl;
  logic [PHASE_BITS-1:0]    cur_phase;
  logic signed [TL_W-1:0]   tl;
  logic [23:0]              tp;
  logic [15:0]              trem;
  logic signed [P1_W-1:0]   prod1;
  logic signed [P2_W-1:0]   prod2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [M1_W-1:0]   m1;
  logic signed [M2_W-1:0]   m2;
  logic signed [C1_W-1:0]   c1;
  logic signed [C2_W-1:0]   c2;
  logic [15:0]              sine_mag;
  logic                     sine_neg;

  // RAM port signals.
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Mix gain lookup.
  logic [15:0]        norm_lut [NSUM];

  // Combinational datapath.
  logic                     last;
  logic                     out_load;
  logic [4:0]               r2;
  logic [63:0]              db_ext;
  logic [95:0]              sc_ext;
  logic [3:0]               nib;
  logic [5:0]               kk;
  logic [3:0]               note_lvl;
  logic [PHASE_BITS-1:0]    note_phase;
  logic [31:0]              mute_prod;
  logic [PHASE_BITS-1:0]    pstep;
  logic [PHASE_BITS-1:0]    rot_inc;
  logic [PHASE_BITS-1:0]    lfo_sum;
  logic [IF_W-1:0]          inc_full;
  logic [IF_W-1:0]          inc_half;
  logic [PHASE_BITS-1:0]    inc_clamp;
  logic [3:0]               chk_lvl;
  logic [PHASE_BITS-1:0]    chk_phase;
  logic signed [D1_W-1:0]   d1;
  logic [PHASE_BITS-1:0]    upd_phase;
  logic [PHASE_BITS-1:0]    sine_phase;
  logic signed [16:0]       sine_val;
  logic signed [21:0]       term;
  logic signed [17:0]       tdiff_s;
  logic signed [S1_W-1:0]   s1;
  logic signed [CK_W-1:0]   ck;
  logic signed [TOT_W-1:0]  total;
  logic signed [SAMPLE_W-1:0] sat;

  dbo_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (PARTIALS),
    .ADDR_W (IW)
  ) u_partial_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Mix gain 8/sum in Q4.12 for each level total in eighths; zero when silent.
  for (genvar g = 0; g < NSUM; g++) begin : g_norm
    localparam int          NORM_DIV = (g == 0) ? 1 : g;
    localparam logic [15:0] NORM_VAL = (g == 0) ? 16'd0 : 16'((32768 + g / 2) / NORM_DIV);
    assign norm_lut[g] = NORM_VAL;
  end

  assign last = (part == IW'(PARTIALS - 1));
  assign r2   = RATIO2[4'(part)];

  // Note-on: per-partial level, mute test and start phase.
  always_comb begin
    db_ext     = 64'(drawbar_levels);
    sc_ext     = 96'(scatter_q);
    nib        = db_ext[4*part +: 4];
    kk         = sc_ext[6*part +: 6];
    mute_prod  = 32'(step_q) * 32'(8'(r2) * 8'd10);
    note_lvl   = (nib > 4'd8) ? 4'd8 : nib;
    if (!(mute_prod < MUTE_LIMIT)) begin
      note_lvl = 4'd0;
    end
    note_phase = BASE_TAB[part] + SCAT_TAB[kk];
  end

  // Render: increments, vibrato, phase update, sine and weighting.
  always_comb begin
    pstep     = PHASE_BITS'((64'(step_q) << UP) >> DN);
    rot_inc   = PHASE_BITS'((64'(rotary_step) << UP) >> DN);
    lfo_sum   = lfo_phase + rot_inc;
    inc_full  = IF_W'(pstep) * IF_W'(r2);
    inc_half  = inc_full >> 1;
    inc_clamp = (inc_half > IF_W'(INC_MAX)) ? INC_MAX : PHASE_BITS'(inc_half);
    chk_lvl   = rd_ok ? ram_rdata[ENTRY_W-1 -: 4] : 4'd0;
    chk_phase = rd_ok ? ram_rdata[PHASE_BITS-1:0] : '0;
    d1        = D1_W'(trunc_shift(longint'(prod1), 15));
    upd_phase = inc + PHASE_BITS'(trunc_shift(longint'(prod2), 30)) + cur_phase;
    sine_val  = sine_neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
    term      = sine_val * $signed({1'b0, cur_lvl});
    tdiff_s   = 18'sd32768 - 18'(sine_val);
    s1        = S1_W'(trunc_shift(longint'(m1), 15));
    ck        = CK_W'(trunc_shift(longint'(c2), 32));
    total     = TOT_W'(trunc_shift(longint'(m2), 15));
    if (click_env > CLICK_MIN) begin
      total = total + TOT_W'(ck);
    end
    if (total > TOT_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (total < -TOT_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = SAMPLE_W'(total);
    end
  end

  // Sequencer: next state, handshakes and RAM port control.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = part;
    ram_raddr  = part;
    ram_wdata  = {note_lvl, note_phase};
    sine_phase = upd_phase;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_NOTE_ON) begin
            state_next = S_NOTE;
          end else if (rotary_amount != 8'd0) begin
            state_next = S_LFO_STEP;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_NOTE: begin
        ram_we = 1'b1;
        if (last) begin
          state_next = S_NOTE_END;
        end
      end
      S_NOTE_END: state_next = S_IDLE;
      S_LFO_STEP: begin
        sine_phase = lfo_sum;
        state_next = S_LFO_MUL;
      end
      S_LFO_MUL:  state_next = S_LFO_TREM;
      S_LFO_TREM: state_next = S_RD;
      S_RD:       state_next = S_CHK;
      S_CHK: begin
        if (chk_lvl != 4'd0) begin
          state_next = S_VIB;
        end else if (last) begin
          state_next = S_MIX;
        end else begin
          state_next = S_RD;
        end
      end
      S_VIB: state_next = S_UPD;
      S_UPD: begin
        ram_we     = 1'b1;
        ram_wdata  = {cur_lvl, upd_phase};
        state_next = S_ACC;
      end
      S_ACC:   state_next = last ? S_MIX : S_RD;
      S_MIX:   state_next = S_SCALE;
      S_SCALE: state_next = S_CLICK;
      S_CLICK: state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state, registers and voice scalars.
  always_ff @(posedge clk) begin
    if (rst) begin
      drawbar_levels <= '0;
      rotary_amount  <= '0;
      click_level    <= '0;
      click_decay    <= CLICK_DECAY_RST;
      rotary_step    <= ROTARY_STEP_RST;
      part           <= '0;
      level_sum      <= '0;
      valid          <= '0;
      mix_norm       <= '0;
      click_env      <= '0;
      lfo_phase      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DRAWBARS:    drawbar_levels <= cfg_data[35:0];
          REG_ROTARY_AMT:  rotary_amount  <= cfg_data[7:0];
          REG_CLICK_LEVEL: click_level    <= cfg_data[7:0];
          REG_CLICK_DECAY: click_decay    <= cfg_data[15:0];
          REG_ROTARY_STEP: rotary_step    <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        part      <= '0;
        level_sum <= '0;
      end
      if (state == S_NOTE) begin
        valid[part] <= 1'b1;
        level_sum   <= level_sum + SUM_W'(note_lvl);
        if (!last) begin
          part <= part + IW'(1);
        end
      end
      if (state == S_NOTE_END) begin
        mix_norm  <= norm_lut[level_sum];
        click_env <= {click_level, click_level};
        lfo_phase <= '0;
      end
      if (state == S_LFO_STEP) begin
        lfo_phase <= lfo_sum;
      end
      if ((state == S_CHK && chk_lvl == 4'd0 && !last) || (state == S_ACC && !last)) begin
        part <= part + IW'(1);
      end
      if (out_load && click_env > CLICK_MIN) begin
        click_env <= 16'((32'(click_env) * 32'(click_decay)) >> 16);
      end
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  // Datapath registers; every value is written before it is used.
  always_ff @(posedge clk) begin
    sine_mag <= SINE_TAB[sine_index(sine_phase)];
    sine_neg <= sine_phase[PHASE_BITS-1];
    if (in_valid && in_ready) begin
      step_q    <= pitch_step;
      scatter_q <= phase_scatter;
      noise_q   <= noise_value;
      acc       <= '0;
      tl        <= '0;
      trem      <= TREM_UNITY;
    end
    unique case (state)
      S_LFO_MUL: begin
        tl <= sine_val * $signed({1'b0, rotary_amount});
        tp <= 24'(rotary_amount) * 24'(tdiff_s[15:0]);
      end
      S_LFO_TREM: trem <= TREM_UNITY - 16'((37'(tp) * 37'(TREM_K)) >> 24);
      S_RD: begin
        rd_ok <= valid[part];
        inc   <= inc_clamp;
      end
      S_CHK: begin
        cur_lvl   <= chk_lvl;
        cur_phase <= chk_phase;
        prod1     <= $signed({1'b0, inc}) * tl;
      end
      S_VIB:   prod2 <= d1 * VIB_K;
      S_ACC:   acc   <= acc + ACC_W'(term);
      S_MIX:   m1    <= acc * $signed({1'b0, mix_norm});
      S_SCALE: begin
        m2 <= s1 * $signed({1'b0, trem});
        c1 <= noise_q * $signed({1'b0, click_env});
      end
      S_CLICK: c2 <= c1 * CLICK_K;
      S_OUT: begin
        if (out_load) begin
          audio_out <= sat;
        end
      end
      default: ;
    endcase
  end

  // A new sample appears only at the end of a render.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("output sample appeared outside the output step");

  // The partial RAM is written only by note-on or by a phase update.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_NOTE || state == S_UPD))
    else $error("partial RAM written outside note-on or phase update");

  // A muted partial never reaches the accumulator.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (cur_lvl != 4'd0))
    else $error("muted partial accumulated");

  // Tremolo gain never exceeds unity once the partial loop starts.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (trem <= TREM_UNITY))
    else $error("tremolo gain above unity");

endmodule
